>>> rtl/core/svm_pkg.sv
package svm_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int SAMPLE_DEPTH = 4096;
  localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
  localparam int POS_W        = 32;
  localparam int NP_W         = POS_W + 2;
  localparam int SMP_W        = 16;
  localparam int MIX_W        = 32;
  localparam int PROD_W       = 32;
  localparam int GAIN_W       = 14;
  localparam int GAIN_SHIFT   = 14;
  localparam int CENTRE_SHIFT = 5;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 24;
  localparam int IN_DATA_W    = 112;
  localparam int OUT_DATA_W   = 72;
  localparam int REQ_W        = 2;

  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_START = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAN        = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_16  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SMP_LENGTH = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_END   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP       = 4'd7;

  localparam logic [1:0] LOOP_NONE = 2'd0;
  localparam logic [1:0] LOOP_FWD  = 2'd1;

  localparam logic [7:0] VOL_MAX      = 8'd128;
  localparam logic [6:0] PAN_MAX      = 7'd64;
  localparam logic [6:0] PAN_CENTRE   = 7'd32;
  localparam logic [6:0] PAN_SURR     = 7'd65;

  typedef struct packed {
    logic do_load;
    logic do_start;
    logic do_capture;
    logic do_advance;
    logic out_load;
  } svm_cmd_t;

endpackage

>>> rtl/core/svm_ctrl.sv
module svm_ctrl
  import svm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic [REQ_W-1:0] in_tuser,
  output logic             in_tready,
  input  logic             out_tready,
  output logic             out_tvalid,
  output svm_cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_ADD  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    out_valid_nxt  = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.do_load    = (in_tuser == REQ_LOAD);
          cmd.do_start   = (in_tuser == REQ_START);
          cmd.do_capture = (in_tuser == REQ_TICK);
          if (in_tuser == REQ_TICK) begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd.do_advance = 1'b1;
        state_nxt      = ST_ADD;
      end
      ST_ADD: begin
        // hold the result until the output register is free
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/core/svm_dp.sv
module svm_dp
  import svm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  svm_cmd_t              cmd,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  // configuration
  logic [7:0]  volume_r;
  logic [6:0]  pan_r;
  logic [1:0]  loop_mode_r;
  logic        sample_16_r;
  logic [12:0] smp_length_r;
  logic [11:0] loop_start_r;
  logic [12:0] loop_end_r;
  logic [23:0] step_r;

  // input fields
  logic [11:0]       load_index;
  logic [SMP_W-1:0]  load_value;
  logic [11:0]       start_position;
  logic [MIX_W-1:0]  acc_left;
  logic [MIX_W-1:0]  acc_right;
  logic              mute;

  assign load_index     = in_tdata[11:0];
  assign load_value     = in_tdata[27:12];
  assign start_position = in_tdata[39:28];
  assign acc_left       = in_tdata[71:40];
  assign acc_right      = in_tdata[103:72];
  assign mute           = in_tdata[104];

  // voice state
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             rev_r, rev_nxt;
  logic             active_r, active_nxt;

  // gains
  logic [GAIN_W-1:0] gain_l_r, gain_r_r, gain_l_nxt, gain_r_nxt;
  logic              surround_r;
  logic [7:0]        vol_c;
  logic [6:0]        pan_c;
  logic              surround;

  // tick pipeline
  logic [SMP_W-1:0]         mem [SAMPLE_DEPTH];
  logic [SMP_W-1:0]         rd_data_r;
  logic [MIX_W-1:0]         acc_l_r, acc_r_r;
  logic                     mute_r;
  logic                     snap_active_r;
  logic signed [PROD_W-1:0] prod_l_r, prod_r_r;
  logic [OUT_DATA_W-1:0]    out_r;

  logic [ADDR_W-1:0]        raddr, waddr;
  logic                     load_ok;
  logic signed [SMP_W-1:0]  smp;
  logic signed [PROD_W-1:0] smp_w, gl_w, gr_w;
  logic signed [NP_W-1:0]   pos_s, inc_s, plus, minus, np, ls, le, len;
  logic                     inc_nz;
  logic signed [PROD_W-1:0] ql, qr;
  logic [MIX_W-1:0]         mix_l, mix_r;
  logic                     mix_on;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r     <= VOL_MAX;
      pan_r        <= PAN_CENTRE;
      loop_mode_r  <= LOOP_NONE;
      sample_16_r  <= 1'b1;
      smp_length_r <= 13'(SAMPLE_DEPTH);
      loop_start_r <= '0;
      loop_end_r   <= 13'(SAMPLE_DEPTH);
      step_r       <= 24'(1 << FRAC_BITS);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VOLUME:     volume_r     <= cfg_wdata[7:0];
        CFG_PAN:        pan_r        <= cfg_wdata[6:0];
        CFG_LOOP_MODE:  loop_mode_r  <= cfg_wdata[1:0];
        CFG_SAMPLE_16:  sample_16_r  <= cfg_wdata[0];
        CFG_SMP_LENGTH: smp_length_r <= cfg_wdata[12:0];
        CFG_LOOP_START: loop_start_r <= cfg_wdata[11:0];
        CFG_LOOP_END:   loop_end_r   <= cfg_wdata[12:0];
        CFG_STEP:       step_r       <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  // gains follow the config registers in the cycle after each write
  always_comb begin
    vol_c    = (volume_r > VOL_MAX) ? VOL_MAX : volume_r;
    pan_c    = (pan_r > PAN_MAX) ? PAN_MAX : pan_r;
    surround = (pan_r == PAN_SURR);
    if (surround || pan_c == PAN_CENTRE) begin
      gain_l_nxt = GAIN_W'(vol_c) << CENTRE_SHIFT;
      gain_r_nxt = gain_l_nxt;
    end else begin
      gain_l_nxt = GAIN_W'(vol_c) * GAIN_W'(PAN_MAX - pan_c);
      gain_r_nxt = GAIN_W'(vol_c) * GAIN_W'(pan_c);
    end
  end

  always_ff @(posedge clk) begin
    gain_l_r   <= gain_l_nxt;
    gain_r_r   <= gain_r_nxt;
    surround_r <= surround;
  end

  // sample store
  assign raddr   = ADDR_W'(pos_r >> FRAC_BITS);
  assign waddr   = ADDR_W'(load_index);
  assign load_ok = (32'(load_index) < 32'(SAMPLE_DEPTH));

  always_ff @(posedge clk) begin
    if (cmd.do_load && load_ok) begin
      mem[waddr] <= load_value;
    end
    if (cmd.do_capture) begin
      rd_data_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_capture) begin
      acc_l_r       <= acc_left;
      acc_r_r       <= acc_right;
      mute_r        <= mute;
      snap_active_r <= active_r;
    end
  end

  // position step; plus and minus cover both the step and its reversal
  always_comb begin
    pos_s  = $signed(NP_W'(pos_r));
    inc_s  = $signed(NP_W'(step_r));
    plus   = pos_s + inc_s;
    minus  = pos_s - inc_s;
    ls     = $signed(NP_W'(loop_start_r) << FRAC_BITS);
    le     = $signed(NP_W'(loop_end_r) << FRAC_BITS);
    len    = $signed(NP_W'(smp_length_r) << FRAC_BITS);
    inc_nz = (step_r != '0);
    np         = rev_r ? minus : plus;
    rev_nxt    = rev_r;
    active_nxt = active_r;
    if (loop_mode_r[1]) begin
      if (rev_r && inc_nz && minus < ls) begin
        rev_nxt = 1'b0;
        np      = plus;
      end else if (!rev_r && inc_nz && plus >= le) begin
        rev_nxt = 1'b1;
        np      = minus;
      end
    end else if (loop_mode_r == LOOP_FWD) begin
      if (np >= le) begin
        np = {ls[NP_W-1:FRAC_BITS], np[FRAC_BITS-1:0]};
      end
    end else if (np >= len) begin
      active_nxt = 1'b0;
    end
    pos_nxt = np[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      rev_r    <= 1'b0;
      active_r <= 1'b0;
    end else if (cmd.do_start) begin
      pos_r    <= POS_W'(start_position) << FRAC_BITS;
      rev_r    <= 1'b0;
      active_r <= 1'b1;
    end else if (cmd.do_advance && snap_active_r) begin
      pos_r    <= pos_nxt;
      rev_r    <= rev_nxt;
      active_r <= active_nxt;
    end
  end

  // 8-bit words: signed low byte times 256
  always_comb begin
    smp   = sample_16_r ? $signed(rd_data_r) : $signed({rd_data_r[7:0], 8'h00});
    smp_w = PROD_W'(smp);
    gl_w  = PROD_W'({1'b0, gain_l_r});
    gr_w  = PROD_W'({1'b0, gain_r_r});
  end

  always_ff @(posedge clk) begin
    if (cmd.do_advance) begin
      prod_l_r <= smp_w * gl_w;
      prod_r_r <= smp_w * gr_w;
    end
  end

  always_comb begin
    ql     = prod_l_r >>> GAIN_SHIFT;
    qr     = prod_r_r >>> GAIN_SHIFT;
    mix_on = snap_active_r && !mute_r;
    mix_l  = acc_l_r;
    mix_r  = acc_r_r;
    if (mix_on) begin
      mix_l = acc_l_r + MIX_W'(ql);
      mix_r = surround_r ? acc_r_r - MIX_W'(ql) : acc_r_r + MIX_W'(qr);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= {7'd0, active_r, mix_r, mix_l};
    end
  end

  assign out_tdata = out_r;

endmodule

>>> rtl/core/sample_voice_mixer_unit.sv
// One wavetable voice with forward and ping-pong looping, mixed into a stereo pair.
// Input stream: in_tuser selects the request (load word, start, mix tick);
// in_tdata carries the payload. Load and start transfers give no result and
// leave the input ready. A tick transfer reads the sample store, steps the position
// and returns one result on the output stream with the two updated
// accumulators and the voice-active flag.
// A tick result passes through the store read, the multiply and step, and the add
// before it is presented. A tick holds the input stream not ready until its result
// is loaded into the output register, so no new transfer is taken meanwhile; loads
// and starts run at one per cycle while the block is idle.
// The output register holds a finished result while out_tready is low; the
// block still takes loads and starts then, and a following tick waits in its
// final stage until the register is free.
// Configuration writes are taken at any edge with cfg_we high and must only
// happen while the block is idle.
// Reset (rst_n low, synchronous) restores the register defaults, clears the
// position, direction and active flag and empties the output. The sample
// store is not cleared; load every word before it is played.
module sample_voice_mixer_unit
  import svm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // load_index, load_value, start_position, acc_left, acc_right, mute
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // req_type
  input  logic [REQ_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // mix_left, mix_right, voice_active
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  svm_cmd_t cmd;

  svm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  svm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

endmodule

>>> rtl/core/svm_chk.sv
module svm_chk
  import svm_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [REQ_W-1:0]      in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a tick transfer occupies the block
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == REQ_TICK |=> !in_tready)
    else $error("input ready right after a tick");

  // loads, starts and unknown requests leave the input ready
  a_other_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser != REQ_TICK |=> in_tready)
    else $error("input stalled after a non-tick transfer");

  // a result appears only from a tick in flight
  a_out_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result without a tick in flight");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("reset did not empty the block");

endmodule

bind sample_voice_mixer_unit svm_chk u_svm_chk (.*);
